// ===== hw/rtl/slpc_pkg.sv =====
// Shared codes and reset constants for the status LED pattern controller.
// No dependencies; imported by status_led_pattern_controller_top.
`default_nettype none

package slpc_pkg;

  // Event codes carried in the op field
  typedef logic [2:0] op_t;
  localparam op_t OpTick        = 3'd0;
  localparam op_t OpSetPattern  = 3'd1;
  localparam op_t OpPress       = 3'd2;
  localparam op_t OpRelease     = 3'd3;
  localparam op_t OpStateChange = 3'd4;

  // Pattern codes
  typedef logic [1:0] pattern_t;
  localparam pattern_t PatOff   = 2'd0;
  localparam pattern_t PatSolid = 2'd1;
  localparam pattern_t PatPulse = 2'd2;
  localparam pattern_t PatBlink = 2'd3;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CfgPulsePeriod = 3'd0;
  localparam cfg_idx_t CfgBlinkPeriod = 3'd1;
  localparam cfg_idx_t CfgPulseLow    = 3'd2;
  localparam cfg_idx_t CfgPulseHigh   = 3'd3;
  localparam cfg_idx_t CfgPulseStep   = 3'd4;

  // Duty levels and reset values
  localparam logic [7:0]  DutyFull          = 8'd255;
  localparam logic [7:0]  DutyZero          = 8'd0;
  localparam logic [15:0] PulsePeriodReset  = 16'd20;
  localparam logic [15:0] BlinkPeriodReset  = 16'd500;
  localparam logic [7:0]  PulseLowReset     = 8'd50;
  localparam logic [7:0]  PulseHighReset    = 8'd255;
  localparam logic [7:0]  PulseStepReset    = 8'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/status_led_pattern_controller_top.sv =====
// Status LED pattern controller: event decode, pattern state and duty result.
// Depends on slpc_pkg for event, pattern and register codes.
//
// Usage:
//   The slave stream takes one event per transaction (tick, pattern request,
//   button press, button release, state-change notice). Every event yields
//   exactly one result on the master stream: the LED duty, the current
//   pattern and the override flag after the event.
//   The configuration channel writes the ramp and period registers; it is
//   always ready and should only be used while no event is in flight.
// Pipeline and throughput:
//   An accepted event is captured in the input register, is processed by the
//   update logic and lands in the result register once that is free or read.
//   One event is taken every cycle while m_axis_tready is not holding the
//   result; the rate is set by the single state update between the two registers.
// Reset:
//   rst_ni clears both stream stages, the pattern state (off, no override,
//   ramp at 50 rising, blink phase off, duty 0) and restores register resets.
// Stall:
//   When m_axis_tready is low with a result pending, the result holds, the input register holds,
//   and s_axis_tready drops once the input register is full.
`default_nettype none

module status_led_pattern_controller_top
  import slpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Event stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [2:0] op, [4:3] pattern, [7:5] zero
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [7:0] duty, [9:8] active_pattern,
                                           // [10] override_on, [15:11] zero
);

  // Configuration registers
  logic [15:0] pulse_period_q, blink_period_q;
  logic [7:0]  pulse_low_q, pulse_high_q, pulse_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_period_q <= PulsePeriodReset;
      blink_period_q <= BlinkPeriodReset;
      pulse_low_q    <= PulseLowReset;
      pulse_high_q   <= PulseHighReset;
      pulse_step_q   <= PulseStepReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_t'(cfg_index_i))
        CfgPulsePeriod: pulse_period_q <= cfg_data_i;
        CfgBlinkPeriod: blink_period_q <= cfg_data_i;
        CfgPulseLow:    pulse_low_q    <= cfg_data_i[7:0];
        CfgPulseHigh:   pulse_high_q   <= cfg_data_i[7:0];
        CfgPulseStep:   pulse_step_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic     in_valid_q;
  op_t      in_op_q;
  pattern_t in_pat_q;
  logic     out_valid_q;
  logic     advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q  <= op_t'(s_axis_tdata[2:0]);
      in_pat_q <= pattern_t'(s_axis_tdata[4:3]);
    end
  end

  // Pattern state
  pattern_t    cur_pat_q, cur_pat_d;
  pattern_t    held_pat_q, held_pat_d;
  logic        override_q, override_d;
  logic [7:0]  ramp_level_q, ramp_level_d;
  logic        ramp_rising_q, ramp_rising_d;
  logic        blink_phase_q, blink_phase_d;
  logic [15:0] tick_count_q, tick_count_d;
  logic [7:0]  duty_q, duty_d;

  // Tick period and ramp step arithmetic
  logic [15:0]       period;
  logic [16:0]       tick_next;
  logic              period_done;
  logic signed [9:0] ramp_next;
  logic              hit_high, hit_low;
  pattern_t          req_pat;
  logic              do_apply;

  always_comb begin
    period      = (cur_pat_q == PatPulse) ? pulse_period_q : blink_period_q;
    if (period == 16'd0) begin
      period = 16'd1;
    end
    tick_next   = {1'b0, tick_count_q} + 17'd1;
    period_done = !(tick_next < {1'b0, period});
    ramp_next   = ramp_rising_q ? $signed({2'b00, ramp_level_q}) + $signed({2'b00, pulse_step_q})
                                : $signed({2'b00, ramp_level_q}) - $signed({2'b00, pulse_step_q});
    hit_high    = ramp_next >= $signed({2'b00, pulse_high_q});
    hit_low     = ramp_next <= $signed({2'b00, pulse_low_q});
  end

  // Event decode and next state
  always_comb begin
    cur_pat_d     = cur_pat_q;
    held_pat_d    = held_pat_q;
    override_d    = override_q;
    ramp_level_d  = ramp_level_q;
    ramp_rising_d = ramp_rising_q;
    blink_phase_d = blink_phase_q;
    tick_count_d  = tick_count_q;
    duty_d        = duty_q;
    req_pat       = in_pat_q;
    do_apply      = 1'b0;

    unique case (in_op_q)
      OpTick: begin
        if (!override_q && (cur_pat_q == PatPulse || cur_pat_q == PatBlink)) begin
          if (!period_done) begin
            tick_count_d = tick_next[15:0];
          end else begin
            tick_count_d = 16'd0;
            if (cur_pat_q == PatPulse) begin
              if (hit_high) begin
                ramp_level_d  = pulse_high_q;
                ramp_rising_d = 1'b0;
              end else if (hit_low) begin
                ramp_level_d  = pulse_low_q;
                ramp_rising_d = 1'b1;
              end else begin
                ramp_level_d  = ramp_next[7:0];
              end
              duty_d = ramp_level_d;
            end else begin
              blink_phase_d = !blink_phase_q;
              duty_d        = blink_phase_d ? DutyFull : DutyZero;
            end
          end
        end
      end
      OpSetPattern: begin
        do_apply = (in_pat_q != cur_pat_q);
      end
      OpPress: begin
        if (!override_q) begin
          held_pat_d = cur_pat_q;
          override_d = 1'b1;
          duty_d     = DutyZero;
        end
      end
      OpRelease: begin
        if (override_q) begin
          override_d = 1'b0;
          cur_pat_d  = PatOff;
          if (held_pat_q == PatOff) begin
            duty_d = DutyZero;
          end else begin
            req_pat  = held_pat_q;
            do_apply = 1'b1;
          end
        end
      end
      OpStateChange: begin
        if (override_q) begin
          duty_d = DutyFull;
        end
      end
      default: ;
    endcase

    // Switch to a new pattern and restart its timing
    if (do_apply) begin
      cur_pat_d    = req_pat;
      tick_count_d = 16'd0;
      case (req_pat)
        PatSolid: duty_d = DutyFull;
        PatPulse: begin
          ramp_level_d  = pulse_low_q;
          ramp_rising_d = 1'b1;
        end
        PatBlink: blink_phase_d = 1'b0;
        default:  duty_d = DutyZero;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pat_q     <= PatOff;
      held_pat_q    <= PatOff;
      override_q    <= 1'b0;
      ramp_level_q  <= PulseLowReset;
      ramp_rising_q <= 1'b1;
      blink_phase_q <= 1'b0;
      tick_count_q  <= 16'd0;
      duty_q        <= DutyZero;
    end else if (advance) begin
      cur_pat_q     <= cur_pat_d;
      held_pat_q    <= held_pat_d;
      override_q    <= override_d;
      ramp_level_q  <= ramp_level_d;
      ramp_rising_q <= ramp_rising_d;
      blink_phase_q <= blink_phase_d;
      tick_count_q  <= tick_count_d;
      duty_q        <= duty_d;
    end
  end

  // Result register
  logic [7:0] out_duty_q;
  pattern_t   out_pat_q;
  logic       out_ovr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_duty_q <= duty_d;
      out_pat_q  <= cur_pat_d;
      out_ovr_q  <= override_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_ovr_q, out_pat_q, out_duty_q};

  // Checks
  a_press_sets_override: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_op_q == OpPress) |=> override_q)
    else $error("press did not set override");

  a_override_freezes_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_op_q == OpTick && override_q) |=> ($stable(tick_count_q) && $stable(duty_q)))
    else $error("tick changed state during override");

  a_state_change_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_op_q == OpStateChange && override_q) |=> (duty_q == DutyFull))
    else $error("state change during override did not drive full duty");

  a_input_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_op_q) && $stable(in_pat_q)))
    else $error("input register lost an event while stalled");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && out_duty_q == duty_q && out_pat_q == cur_pat_q))
    else $error("result register out of step with state");

endmodule

`default_nettype wire
